### hdl/aptsc_pkg.sv
// ---------------------------------------------------------------------------
// aptsc_pkg
// Types, register codes and helpers shared by the step counter core.
// ---------------------------------------------------------------------------
package aptsc_pkg;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;
  localparam int unsigned NUM_AXES = 3;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INTERVAL_MIN = 3'd0;
  localparam cfg_idx_t CFG_INTERVAL_MAX = 3'd1;
  localparam cfg_idx_t CFG_SWING_GATE   = 3'd2;
  localparam cfg_idx_t CFG_SWING_COUNT  = 3'd3;
  localparam cfg_idx_t CFG_TICK_STEP    = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] RST_INTERVAL_MIN = 16'd200;
  localparam logic [15:0] RST_INTERVAL_MAX = 16'd2000;
  localparam logic [12:0] RST_SWING_GATE   = 13'd35;
  localparam logic [12:0] RST_SWING_COUNT  = 13'd42;
  localparam logic [9:0]  RST_TICK_STEP    = 10'd25;

  // offset sample range is -1536..2559, magnitude limit used for filter sizing
  typedef logic signed [12:0] smp_t;
  localparam smp_t SAMPLE_OFFSET = 13'sd512;
  localparam int unsigned SMP_MAG_LIMIT = 2560;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  // result queue
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = 2;
  localparam int unsigned OUTQ_CNT_W = 3;

  typedef struct packed {
    logic signed [11:0] accel_x;
    logic signed [11:0] accel_y;
    logic signed [11:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [23:0] total_steps;
    logic [23:0] x_steps;
    logic [23:0] y_steps;
    logic [23:0] z_steps;
    logic [23:0] wave_total;
    logic [31:0] swing_sum;
  } out_t;

  typedef struct packed {
    logic [15:0] interval_min;
    logic [15:0] interval_max;
    logic [12:0] swing_gate;
    logic [12:0] swing_count;
    logic [9:0]  tick_step;
  } cfg_t;

  // one raw axis sample entering the filter
  typedef struct packed {
    logic               vld;
    axis_t              axis;
    logic signed [11:0] raw;
  } s0_t;

  // window memory read request
  typedef struct packed {
    logic  vld;
    axis_t axis;
  } prd_t;

  // filtered axis sample
  typedef struct packed {
    logic  vld;
    axis_t axis;
    smp_t  value;
  } flt_t;

  // trough result handed to the counters
  typedef struct packed {
    logic               vld;
    axis_t              axis;
    logic               trough;
    logic               dt_ok;
    logic signed [13:0] swing;
  } pk_t;

  function automatic logic [23:0] sat_inc24(logic [23:0] v);
    return (v == CNT_MAX) ? v : v + 24'd1;
  endfunction

endpackage

### hdl/aptsc_filter.sv
// ---------------------------------------------------------------------------
// aptsc_filter
// Per-axis moving average: history and running sum live in a small
// memory, read-modify-written once per axis slot, then divided by the tap
// count through a reciprocal multiply.
// ---------------------------------------------------------------------------
module aptsc_filter #(
  parameter int unsigned FILTER_TAPS = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aptsc_pkg::s0_t   s0_i,
  output aptsc_pkg::prd_t  prd_o,
  output aptsc_pkg::flt_t  flt_o
);

  localparam int unsigned HIST_N  = FILTER_TAPS - 1;
  localparam int unsigned MAG_W   = $clog2(FILTER_TAPS * aptsc_pkg::SMP_MAG_LIMIT);
  localparam int unsigned FSUM_W  = MAG_W + 1;
  localparam int unsigned DIV_SH  = MAG_W + $clog2(FILTER_TAPS);
  localparam int unsigned RECIP_W = MAG_W + 1;
  localparam int unsigned RECIP   = ((1 << DIV_SH) + FILTER_TAPS - 1) / FILTER_TAPS;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  typedef struct packed {
    logic [HIST_N-1:0][12:0] hist;  // hist[0] oldest
    logic [FSUM_W-1:0]       sum;   // sum of hist
  } fent_t;

  fent_t       mem_q [aptsc_pkg::NUM_AXES];
  logic [2:0]  ent_vld_q;
  fent_t       rd_q;
  logic        rd_vld_q;

  logic                    s1_vld_q;
  aptsc_pkg::axis_t        s1_axis_q;
  aptsc_pkg::smp_t         s1_smp_q;
  aptsc_pkg::smp_t         s0_smp;

  logic                    s2_vld_q;
  aptsc_pkg::axis_t        s2_axis_q;
  logic signed [FSUM_W-1:0] s2_sum_q;

  aptsc_pkg::flt_t         flt_q;

  fent_t                    ent;
  fent_t                    wr_ent;
  logic signed [FSUM_W-1:0] fsum;

  logic                     neg;
  logic signed [FSUM_W-1:0] abs_sum;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        qfull;
  aptsc_pkg::smp_t          qv;

  assign s0_smp = aptsc_pkg::smp_t'(s0_i.raw) + aptsc_pkg::SAMPLE_OFFSET;

  // stage 1: update history with the new sample
  always_comb begin
    ent    = rd_vld_q ? rd_q : '0;
    fsum   = $signed(ent.sum) + FSUM_W'(s1_smp_q);
    wr_ent = ent;
    for (int i = 0; i < int'(HIST_N) - 1; i++) begin
      wr_ent.hist[i] = ent.hist[i+1];
    end
    wr_ent.hist[HIST_N-1] = s1_smp_q;
    wr_ent.sum = $signed(ent.sum) - FSUM_W'($signed(ent.hist[0])) + FSUM_W'(s1_smp_q);
  end

  // stage 2: divide by the tap count, truncating toward zero
  always_comb begin
    neg     = s2_sum_q[FSUM_W-1];
    abs_sum = neg ? -s2_sum_q : s2_sum_q;
    mag     = abs_sum[MAG_W-1:0];
    prod    = PROD_W'(mag) * PROD_W'(RECIP_C);
    qfull   = prod >> DIV_SH;
    qv      = {1'b0, qfull[11:0]};
    if (neg) begin
      qv = -qv;
    end
  end

  // successive slots of the same axis are separated by the other two axis
  // slots, so the write of one slot always lands before the next read of the same entry
  always_ff @(posedge clk_i) begin
    if (s0_i.vld) begin
      rd_q <= mem_q[s0_i.axis];
    end
    if (s1_vld_q) begin
      mem_q[s1_axis_q] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_axis_q <= aptsc_pkg::AXIS_X;
      s1_smp_q  <= '0;
      s2_vld_q  <= 1'b0;
      s2_axis_q <= aptsc_pkg::AXIS_X;
      s2_sum_q  <= '0;
      flt_q     <= '0;
    end else begin
      if (s0_i.vld) begin
        rd_vld_q <= ent_vld_q[s0_i.axis];
      end
      if (s1_vld_q) begin
        ent_vld_q[s1_axis_q] <= 1'b1;
      end
      s1_vld_q    <= s0_i.vld;
      s1_axis_q   <= s0_i.axis;
      s1_smp_q    <= s0_smp;
      s2_vld_q    <= s1_vld_q;
      s2_axis_q   <= s1_axis_q;
      s2_sum_q    <= fsum;
      flt_q.vld   <= s2_vld_q;
      flt_q.axis  <= s2_axis_q;
      flt_q.value <= qv;
    end
  end

  assign prd_o.vld  = s2_vld_q;
  assign prd_o.axis = s2_axis_q;
  assign flt_o      = flt_q;

endmodule

### hdl/aptsc_peak.sv
// ---------------------------------------------------------------------------
// aptsc_peak
// Per-axis crest and trough detection over a five-sample window. Window,
// axis high/low and last trough time sit in a small memory; time base
// advances once per sample.
// ---------------------------------------------------------------------------
module aptsc_peak (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aptsc_pkg::cfg_t  cfg_i,
  input  aptsc_pkg::prd_t  prd_i,
  input  aptsc_pkg::flt_t  flt_i,
  output aptsc_pkg::pk_t   pk_o
);

  typedef struct packed {
    logic [3:0][12:0] win;   // win[0] oldest
    logic [12:0]      high;
    logic [12:0]      low;
    logic [31:0]      last;
  } pent_t;

  pent_t       mem_q [aptsc_pkg::NUM_AXES];
  logic [2:0]  ent_vld_q;
  pent_t       rd_q;
  logic        rd_vld_q;
  logic [31:0] time_q;
  aptsc_pkg::pk_t pk_q;

  pent_t              ent;
  pent_t              wr_ent;
  aptsc_pkg::smp_t    w [5];
  aptsc_pkg::smp_t    mx;
  aptsc_pkg::smp_t    mn;
  aptsc_pkg::smp_t    new_high;
  aptsc_pkg::smp_t    new_low;
  logic               crest;
  logic               trough;
  logic [31:0]        dt;
  logic               dt_ok;
  logic signed [13:0] swing;

  always_comb begin
    ent = rd_vld_q ? rd_q : '0;
    for (int i = 0; i < 4; i++) begin
      w[i] = ent.win[i];
    end
    w[4] = flt_i.value;

    crest  = (w[0] < w[1] && w[1] < w[2] && w[2] > w[3] && w[3] > w[4]) ||
             (w[0] == w[1] && w[1] > w[2] && w[2] > w[3] && w[3] > w[4]) ||
             (w[3] > w[2] && w[3] > w[4]);
    trough = (w[0] > w[1] && w[1] > w[2] && w[2] < w[3] && w[3] <= w[4]) ||
             (w[0] == w[1] && w[1] < w[2] && w[2] < w[3] && w[3] <= w[4]) ||
             (w[3] < w[2] && w[3] < w[4]);

    mx = w[0];
    mn = w[0];
    for (int i = 1; i < 5; i++) begin
      if (w[i] > mx) begin
        mx = w[i];
      end
      if (w[i] < mn) begin
        mn = w[i];
      end
    end

    new_high = crest ? mx : $signed(ent.high);
    new_low  = trough ? mn : $signed(ent.low);
    swing    = 14'(new_high) - 14'(new_low);

    dt    = time_q - ent.last;
    dt_ok = (dt >= 32'(cfg_i.interval_min)) && (dt <= 32'(cfg_i.interval_max));

    wr_ent.win[0] = ent.win[1];
    wr_ent.win[1] = ent.win[2];
    wr_ent.win[2] = ent.win[3];
    wr_ent.win[3] = flt_i.value;
    wr_ent.high   = new_high;
    wr_ent.low    = new_low;
    wr_ent.last   = trough ? time_q : ent.last;
  end

  always_ff @(posedge clk_i) begin
    if (prd_i.vld) begin
      rd_q <= mem_q[prd_i.axis];
    end
    if (flt_i.vld) begin
      mem_q[flt_i.axis] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      time_q    <= '0;
      pk_q      <= '0;
    end else begin
      if (prd_i.vld) begin
        rd_vld_q <= ent_vld_q[prd_i.axis];
      end
      if (flt_i.vld) begin
        ent_vld_q[flt_i.axis] <= 1'b1;
      end
      // time moves on after the last axis of a sample
      if (flt_i.vld && flt_i.axis == aptsc_pkg::AXIS_Z) begin
        time_q <= time_q + 32'(cfg_i.tick_step);
      end
      pk_q.vld    <= flt_i.vld;
      pk_q.axis   <= flt_i.axis;
      pk_q.trough <= trough;
      pk_q.dt_ok  <= dt_ok;
      pk_q.swing  <= swing;
    end
  end

  assign pk_o = pk_q;

endmodule

### hdl/aptsc_count.sv
// ---------------------------------------------------------------------------
// aptsc_count
// Step, linked, wave and swing counters updated on each trough, one axis
// per cycle in x, y, z order; builds the result after the z axis.
// ---------------------------------------------------------------------------
module aptsc_count (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aptsc_pkg::cfg_t  cfg_i,
  input  aptsc_pkg::pk_t   pk_i,
  output logic             res_vld_o,
  output aptsc_pkg::out_t  res_o
);

  logic [23:0] link_q  [aptsc_pkg::NUM_AXES];
  logic [23:0] link_d  [aptsc_pkg::NUM_AXES];
  logic [23:0] axcnt_q [aptsc_pkg::NUM_AXES];
  logic [23:0] axcnt_d [aptsc_pkg::NUM_AXES];
  logic [23:0] steps_q, steps_d;
  logic [23:0] wave_q, wave_d;
  logic [31:0] swsum_q, swsum_d;

  logic [23:0]        own;
  logic [23:0]        oa;
  logic [23:0]        ob;
  logic [23:0]        m;
  logic [24:0]        t;
  logic [23:0]        link_new;
  logic signed [14:0] swing_ext;
  logic               gated;
  logic               counted;
  logic               wave_hit;
  logic [32:0]        sum33;

  always_comb begin
    own = link_q[aptsc_pkg::AXIS_X];
    oa  = link_q[aptsc_pkg::AXIS_Y];
    ob  = link_q[aptsc_pkg::AXIS_Z];
    case (pk_i.axis)
      aptsc_pkg::AXIS_X: begin
        own = link_q[aptsc_pkg::AXIS_X];
        oa  = link_q[aptsc_pkg::AXIS_Y];
        ob  = link_q[aptsc_pkg::AXIS_Z];
      end
      aptsc_pkg::AXIS_Y: begin
        own = link_q[aptsc_pkg::AXIS_Y];
        oa  = link_q[aptsc_pkg::AXIS_Z];
        ob  = link_q[aptsc_pkg::AXIS_X];
      end
      aptsc_pkg::AXIS_Z: begin
        own = link_q[aptsc_pkg::AXIS_Z];
        oa  = link_q[aptsc_pkg::AXIS_X];
        ob  = link_q[aptsc_pkg::AXIS_Y];
      end
      default: begin
        own = '0;
        oa  = '0;
        ob  = '0;
      end
    endcase

    m = (oa > ob) ? oa : ob;
    t = {1'b0, own} + 25'd1;

    swing_ext = {pk_i.swing[13], pk_i.swing};
    gated     = pk_i.vld && pk_i.trough && pk_i.dt_ok &&
                (swing_ext > $signed({2'b00, cfg_i.swing_gate}));
    counted   = gated && (swing_ext > $signed({2'b00, cfg_i.swing_count}));
    wave_hit  = gated && ({1'b0, m} <= t);

    // linked count catches up with the leading other axis
    link_new = aptsc_pkg::sat_inc24(own);
    if (link_new < m) begin
      link_new = m;
    end

    for (int i = 0; i < int'(aptsc_pkg::NUM_AXES); i++) begin
      link_d[i]  = link_q[i];
      axcnt_d[i] = axcnt_q[i];
      if (counted && pk_i.axis == aptsc_pkg::axis_t'(i)) begin
        link_d[i]  = link_new;
        axcnt_d[i] = aptsc_pkg::sat_inc24(axcnt_q[i]);
      end
    end
    steps_d = counted ? link_new : steps_q;

    // swing is positive here and below 4096
    sum33   = {1'b0, swsum_q} + 33'(pk_i.swing[11:0]);
    wave_d  = wave_hit ? aptsc_pkg::sat_inc24(wave_q) : wave_q;
    swsum_d = swsum_q;
    if (wave_hit) begin
      swsum_d = sum33[32] ? '1 : sum33[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(aptsc_pkg::NUM_AXES); i++) begin
        link_q[i]  <= '0;
        axcnt_q[i] <= '0;
      end
      steps_q <= '0;
      wave_q  <= '0;
      swsum_q <= '0;
    end else begin
      for (int i = 0; i < int'(aptsc_pkg::NUM_AXES); i++) begin
        link_q[i]  <= link_d[i];
        axcnt_q[i] <= axcnt_d[i];
      end
      steps_q <= steps_d;
      wave_q  <= wave_d;
      swsum_q <= swsum_d;
    end
  end

  assign res_vld_o         = pk_i.vld && (pk_i.axis == aptsc_pkg::AXIS_Z);
  assign res_o.total_steps = steps_d;
  assign res_o.x_steps     = axcnt_d[aptsc_pkg::AXIS_X];
  assign res_o.y_steps     = axcnt_d[aptsc_pkg::AXIS_Y];
  assign res_o.z_steps     = axcnt_d[aptsc_pkg::AXIS_Z];
  assign res_o.wave_total  = wave_d;
  assign res_o.swing_sum   = swsum_d;

endmodule

### hdl/accel_peak_trough_step_counter_core.sv
// ---------------------------------------------------------------------------
// accel_peak_trough_step_counter_core
// Three-axis accelerometer step counter with peak/trough detection.
// ---------------------------------------------------------------------------
// A new sample is accepted while the sequencer is idle or in its z slot: the axes
// share the filter and window memories and pass through them one axis per cycle,
// x then y then z, so a new sample enters while the previous one is still in
// flight. A result passes the filter and peak registers and the count logic
// before it reaches the output queue; the queue holds 4 results and, beyond the
// axis sequencing, input is held off only when 4 samples are pending.
// Per-axis state is cleared by valid bits at reset, so there is no
// clearing pass. Configuration writes are always taken.
module accel_peak_trough_step_counter_core #(
  parameter int unsigned FILTER_TAPS = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  aptsc_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output aptsc_pkg::out_t                    out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  aptsc_pkg::cfg_idx_t                cfg_index_i,
  input  logic [aptsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  aptsc_pkg::cfg_t  cfg_q, cfg_d;

  logic             busy_q, busy_d;
  aptsc_pkg::axis_t phase_q, phase_d;
  aptsc_pkg::in_t   item_q;
  logic             in_xfer;
  logic             seq_free;

  aptsc_pkg::s0_t   s0;
  aptsc_pkg::prd_t  prd;
  aptsc_pkg::flt_t  flt;
  aptsc_pkg::pk_t   pk;
  logic             res_vld;
  aptsc_pkg::out_t  res;

  aptsc_pkg::out_t                    fifo_q [aptsc_pkg::OUTQ_DEPTH];
  logic [aptsc_pkg::OUTQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [aptsc_pkg::OUTQ_CNT_W-1:0]   fill_q, fill_d;
  logic [aptsc_pkg::OUTQ_CNT_W-1:0]   pend_q, pend_d;
  logic                               out_xfer;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        aptsc_pkg::CFG_INTERVAL_MIN: cfg_d.interval_min = cfg_data_i;
        aptsc_pkg::CFG_INTERVAL_MAX: cfg_d.interval_max = cfg_data_i;
        aptsc_pkg::CFG_SWING_GATE:   cfg_d.swing_gate   = cfg_data_i[12:0];
        aptsc_pkg::CFG_SWING_COUNT:  cfg_d.swing_count  = cfg_data_i[12:0];
        aptsc_pkg::CFG_TICK_STEP:    cfg_d.tick_step    = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_min <= aptsc_pkg::RST_INTERVAL_MIN;
      cfg_q.interval_max <= aptsc_pkg::RST_INTERVAL_MAX;
      cfg_q.swing_gate   <= aptsc_pkg::RST_SWING_GATE;
      cfg_q.swing_count  <= aptsc_pkg::RST_SWING_COUNT;
      cfg_q.tick_step    <= aptsc_pkg::RST_TICK_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // axis sequencer: a sample occupies one slot per axis
  assign seq_free   = !busy_q || (phase_q == aptsc_pkg::AXIS_Z);
  assign in_ready_o = seq_free &&
                      (pend_q != aptsc_pkg::OUTQ_CNT_W'(aptsc_pkg::OUTQ_DEPTH));
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    if (in_xfer) begin
      busy_d  = 1'b1;
      phase_d = aptsc_pkg::AXIS_X;
    end else if (busy_q) begin
      if (phase_q == aptsc_pkg::AXIS_Z) begin
        busy_d = 1'b0;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= aptsc_pkg::AXIS_X;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    s0.vld  = busy_q;
    s0.axis = phase_q;
    case (phase_q)
      aptsc_pkg::AXIS_X: s0.raw = item_q.accel_x;
      aptsc_pkg::AXIS_Y: s0.raw = item_q.accel_y;
      aptsc_pkg::AXIS_Z: s0.raw = item_q.accel_z;
      default:           s0.raw = item_q.accel_x;
    endcase
  end

  aptsc_filter #(
    .FILTER_TAPS (FILTER_TAPS)
  ) u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s0_i   (s0),
    .prd_o  (prd),
    .flt_o  (flt)
  );

  aptsc_peak u_peak (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .prd_i  (prd),
    .flt_i  (flt),
    .pk_o   (pk)
  );

  aptsc_count u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pk_i      (pk),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // result queue; pending count reserves a slot for every sample in flight
  assign out_xfer    = out_valid_o && out_ready_i;
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (res_vld && !out_xfer) begin
      fill_d = fill_q + 3'd1;
    end else if (!res_vld && out_xfer) begin
      fill_d = fill_q - 3'd1;
    end
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      pend_q   <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

endmodule

### hdl/aptsc_assert.sv
// ---------------------------------------------------------------------------
// aptsc_assert
// Port-level properties of the step counter core, bound to the top level.
// ---------------------------------------------------------------------------
module aptsc_assert (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input aptsc_pkg::out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one sample takes a slot for each axis, so no transfer right after another
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in consecutive cycles");

  // every wave adds a swing of at least one
  a_swing_vs_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.swing_sum >= 32'(out_data_o.wave_total))
    else $error("swing sum below wave count");

  // a total only moves when some axis counted a step
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.x_steps == 24'd0 && out_data_o.y_steps == 24'd0 &&
    out_data_o.z_steps == 24'd0 |-> out_data_o.total_steps == 24'd0)
    else $error("total steps without axis steps");

endmodule

bind accel_peak_trough_step_counter_core aptsc_assert u_aptsc_assert (.*);

### verif/tb_accel_peak_trough_step_counter_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_accel_peak_trough_step_counter_core
// Self-checking bench for the peak/trough step counter. A scoreboard class
// predicts every result from the accepted samples and the register values,
// and compares each result transfer field by field. Stimulus is a short set
// of extreme samples and then bursts of triangle waves, plateaus and noise,
// run under several register settings with random sender and receiver stalls.
// ---------------------------------------------------------------------------
module tb_accel_peak_trough_step_counter_core;

  localparam int TAPS           = 9;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;
  localparam aptsc_pkg::cfg_idx_t CFG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  aptsc_pkg::in_t                   in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  aptsc_pkg::out_t                  out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  aptsc_pkg::cfg_idx_t              cfg_index = aptsc_pkg::CFG_INTERVAL_MIN;
  logic [aptsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  accel_peak_trough_step_counter_core #(
    .FILTER_TAPS(TAPS)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  class step_scoreboard;
    bit [15:0] imin, imax;
    bit [12:0] gate, cnt_gate;
    bit [9:0]  tick;
    int        hist[3][TAPS];
    int        win[3][5];
    int        hi[3], lo[3];
    bit [31:0] last_t[3];
    bit [31:0] now;
    bit [23:0] linked[3], steps[3], total, waves;
    bit [31:0] swings;
    aptsc_pkg::out_t expq[$];
    int        errors, seen, checked;

    function new();
      imin     = aptsc_pkg::RST_INTERVAL_MIN;
      imax     = aptsc_pkg::RST_INTERVAL_MAX;
      gate     = aptsc_pkg::RST_SWING_GATE;
      cnt_gate = aptsc_pkg::RST_SWING_COUNT;
      tick     = aptsc_pkg::RST_TICK_STEP;
    endfunction

    function bit [23:0] bump24(bit [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    function void write_reg(aptsc_pkg::cfg_idx_t idx,
                            logic [aptsc_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        aptsc_pkg::CFG_INTERVAL_MIN: imin = d;
        aptsc_pkg::CFG_INTERVAL_MAX: imax = d;
        aptsc_pkg::CFG_SWING_GATE:   gate = d[12:0];
        aptsc_pkg::CFG_SWING_COUNT:  cnt_gate = d[12:0];
        aptsc_pkg::CFG_TICK_STEP:    tick = d[9:0];
        default: ;
      endcase
    endfunction

    function void note_sample(aptsc_pkg::in_t s);
      int        raw[3];
      int        a, i, acc, f, mn, mx, swing;
      int        w0, w1, w2, w3, w4;
      bit        crest, trough;
      bit [31:0] dt;
      bit [24:0] t;
      bit [23:0] m;
      bit [32:0] sum;
      aptsc_pkg::out_t r;
      raw[0] = $signed(s.accel_x);
      raw[1] = $signed(s.accel_y);
      raw[2] = $signed(s.accel_z);
      for (a = 0; a < 3; a++) begin
        // moving average, divide truncates toward zero
        acc = 0;
        for (i = 0; i < TAPS - 1; i++) begin
          hist[a][i] = hist[a][i + 1];
          acc += hist[a][i];
        end
        hist[a][TAPS - 1] = raw[a] + 512;
        acc += hist[a][TAPS - 1];
        f = acc / TAPS;

        for (i = 0; i < 4; i++) win[a][i] = win[a][i + 1];
        win[a][4] = f;
        w0 = win[a][0]; w1 = win[a][1]; w2 = win[a][2]; w3 = win[a][3]; w4 = win[a][4];
        mx = w0;
        mn = w0;
        for (i = 1; i < 5; i++) begin
          if (win[a][i] > mx) mx = win[a][i];
          if (win[a][i] < mn) mn = win[a][i];
        end

        crest = (w0 < w1 && w1 < w2 && w2 > w3 && w3 > w4) ||
                (w0 == w1 && w1 > w2 && w2 > w3 && w3 > w4) ||
                (w3 > w2 && w3 > w4);
        if (crest) hi[a] = mx;

        trough = (w0 > w1 && w1 > w2 && w2 < w3 && w3 <= w4) ||
                 (w0 == w1 && w1 < w2 && w2 < w3 && w3 <= w4) ||
                 (w3 < w2 && w3 < w4);
        if (trough) begin
          lo[a] = mn;
          swing = hi[a] - lo[a];
          dt = now - last_t[a];
          if (dt >= imin && dt <= imax && swing > int'(gate)) begin
            t = {1'b0, linked[a]} + 25'd1;
            m = (linked[(a + 1) % 3] > linked[(a + 2) % 3]) ?
                linked[(a + 1) % 3] : linked[(a + 2) % 3];
            if (swing > int'(cnt_gate)) begin
              steps[a]  = bump24(steps[a]);
              linked[a] = bump24(linked[a]);
              if (linked[a] < m) linked[a] = m;
              total = linked[a];
            end
            if ({1'b0, m} <= t) begin
              waves  = bump24(waves);
              sum    = {1'b0, swings} + 33'(swing);
              swings = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            end
          end
          last_t[a] = now;
        end
      end
      now += {22'b0, tick};

      r.total_steps = total;
      r.x_steps     = steps[0];
      r.y_steps     = steps[1];
      r.z_steps     = steps[2];
      r.wave_total  = waves;
      r.swing_sum   = swings;
      expq.push_back(r);
      seen++;
    endfunction

    function void check_result(aptsc_pkg::out_t got);
      aptsc_pkg::out_t want;
      logic [31:0] e[6], g[6];
      string       nm[6];
      string       bad;
      int          i;
      if (expq.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, actual %0d %0d %0d %0d %0d %0d",
                   $time, got.total_steps, got.x_steps, got.y_steps, got.z_steps,
                   got.wave_total, got.swing_sum);
        return;
      end
      want = expq.pop_front();
      checked++;
      nm = '{"total_steps", "x_steps", "y_steps", "z_steps", "wave_total", "swing_sum"};
      e = '{32'(want.total_steps), 32'(want.x_steps), 32'(want.y_steps),
            32'(want.z_steps), 32'(want.wave_total), want.swing_sum};
      g = '{32'(got.total_steps), 32'(got.x_steps), 32'(got.y_steps),
            32'(got.z_steps), 32'(got.wave_total), got.swing_sum};
      bad = "";
      for (i = 0; i < 6; i++)
        if (g[i] !== e[i]) bad = {bad, " ", nm[i]};
      if (bad != "") begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t ns: result %0d wrong in%s: expected %0d %0d %0d %0d %0d %0d,",
                    " actual %0d %0d %0d %0d %0d %0d"},
                   $time, checked, bad, e[0], e[1], e[2], e[3], e[4], e[5],
                   g[0], g[1], g[2], g[3], g[4], g[5]);
        else if (errors == MAX_REPORTS + 1)
          $display("%0t ns: further wrong results are counted but not listed", $time);
      end
    endfunction
  endclass

  step_scoreboard sb = new();

  int  idle_cycles = 0;
  int  cfg_writes = 0;
  int  settings = 1;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  burst_left = 0;
  int  rx_left = 0;
  bit  rx_on = 1'b0;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t ns: watchdog, no transfer for %0d cycles", $time, idle_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // receiver: alternating runs of ready and stall
  always @(negedge clk) begin
    if (rx_steady) begin
      out_ready = 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_on   = !rx_on;
        rx_left = rx_on ? $urandom_range(20, 1) : $urandom_range(12, 1);
      end
      rx_left--;
      out_ready = rx_on;
    end
  end

  task automatic send_sample(input aptsc_pkg::in_t s);
    int gap;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap = $urandom_range(15, 0);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input aptsc_pkg::cfg_idx_t idx,
                           input logic [aptsc_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(input logic [15:0] imin, input logic [15:0] imax,
                               input logic [12:0] gate, input logic [12:0] cnt,
                               input logic [9:0] tick, input bit junk);
    logic [2:0] up3;
    logic [5:0] up6;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    up3 = junk ? 3'($urandom_range(7, 0)) : 3'd0;
    up6 = junk ? 6'($urandom_range(63, 0)) : 6'd0;
    write_cfg(aptsc_pkg::CFG_INTERVAL_MIN, imin);
    write_cfg(aptsc_pkg::CFG_INTERVAL_MAX, imax);
    write_cfg(aptsc_pkg::CFG_SWING_GATE, {up3, gate});
    write_cfg(aptsc_pkg::CFG_SWING_COUNT, {up3, cnt});
    write_cfg(aptsc_pkg::CFG_TICK_STEP, {up6, tick});
    settings++;
  endtask

  task automatic run_directed();
    aptsc_pkg::in_t s;
    int  i;
    s.accel_x = 12'h000; s.accel_y = 12'hFFF; s.accel_z = 12'h555;
    send_sample(s);
    s.accel_x = 12'hFFF; s.accel_y = 12'h000; s.accel_z = 12'hAAA;
    send_sample(s);
    // full-scale steps give long ramps, plateaus and sharp turns after the filter
    for (i = 0; i < 8; i++) begin
      s.accel_x = 12'h7FF; s.accel_y = 12'h800; s.accel_z = 12'h555;
      send_sample(s);
    end
    for (i = 0; i < 8; i++) begin
      s.accel_x = 12'h800; s.accel_y = 12'h7FF; s.accel_z = 12'hAAA;
      send_sample(s);
    end
    for (i = 0; i < 4; i++) begin
      s = '0;
      send_sample(s);
    end
  endtask

  // triangle waves per axis with random period, level and noise,
  // mixed with plateaus and full-range noise segments
  task automatic play_waves(input int n);
    int  k, a, seg, kind, nz, d, half;
    int  per[3], amp[3], ctr[3], ph[3], v[3];
    aptsc_pkg::in_t s;
    seg  = 0;
    kind = 0;
    nz   = 0;
    for (k = 0; k < n; k++) begin
      if (seg == 0) begin
        seg  = $urandom_range(100, 20);
        kind = $urandom_range(9, 0);
        nz   = $urandom_range(1, 0) ? 0 : $urandom_range(64, 1);
        for (a = 0; a < 3; a++) begin
          per[a] = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 4)
                                                : $urandom_range(40, 8);
          amp[a] = $urandom_range(2047, 0);
          ctr[a] = int'($urandom_range(2047, 0)) - 1024;
          ph[a]  = $urandom_range(per[a] - 1, 0);
        end
      end
      seg--;
      for (a = 0; a < 3; a++) begin
        if (kind < 2) begin
          v[a] = int'($urandom_range(4095, 0)) - 2048;
        end else if (kind == 2) begin
          v[a] = ctr[a];
        end else begin
          half = per[a] / 2;
          d = (k + ph[a]) % per[a];
          if (d > half) d = per[a] - d;
          v[a] = ctr[a] - amp[a] + (2 * amp[a] * d) / half;
          if (nz > 0) v[a] += int'($urandom_range(2 * nz, 0)) - nz;
          // clipping flattens the tops and bottoms
          if (v[a] > 2047) v[a] = 2047;
          if (v[a] < -2048) v[a] = -2048;
        end
      end
      s.accel_x = 12'(v[0]);
      s.accel_y = 12'(v[1]);
      s.accel_z = 12'(v[2]);
      send_sample(s);
      if ($urandom_range(199, 0) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [15:0] imin, imax;
    logic [9:0]  tick;
    int          p;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of all registers
    run_directed();
    play_waves(200);

    // widest window, no swing gates, finest time
    apply_setting(16'd0, 16'hFFFF, 13'd0, 13'd0, 10'd1, 1'b0);
    play_waves(120);

    // highest limits and gates, nothing can count
    apply_setting(16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, 10'd1000, 1'b0);
    play_waves(80);

    // crossed interval limits
    apply_setting(16'd3000, 16'd100, 13'd10, 13'd20, 10'd25, 1'b0);
    play_waves(80);

    // frozen time: after the first trough on each axis, every trough sees zero elapsed time
    apply_setting(16'd0, 16'd0, 13'd5, 13'd15, 10'd0, 1'b0);
    write_cfg(CFG_UNUSED, 16'($urandom_range(65535, 0)));
    play_waves(120);

    apply_setting(16'd5000, 16'd40000, 13'd20, 13'd60, 10'h3FF, 1'b1);
    play_waves(120);

    // count gate below wave gate, no stalls on either side
    apply_setting(16'd200, 16'd2000, 13'd80, 13'd30, 10'd25, 1'b0);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    play_waves(150);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    for (p = 0; p < 4; p++) begin
      tick = 10'($urandom_range(1000, 1));
      imin = 16'(tick * $urandom_range(10, 2));
      imax = 16'(imin + tick * $urandom_range(60, 0));
      apply_setting(imin, imax, 13'($urandom_range(200, 0)), 13'($urandom_range(200, 0)),
                    tick, 1'b1);
      play_waves(130);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d results under %0d register settings (%0d writes)",
             sb.seen, sb.checked, settings, cfg_writes);
    $display("final counts: steps %0d, waves %0d, swing sum %0d, wrong results %0d",
             sb.total, sb.waves, sb.swings, sb.errors);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
